### design/rqfp_pkg.sv
// ---------------------------------------------------------------------------
// rqfp_pkg
// Shared types and constants of the ring queue with front push.
// ---------------------------------------------------------------------------
package rqfp_pkg;

  // Fixed widths of the transaction fields
  localparam int unsigned ItemPortW = 32;
  localparam int unsigned CountW    = 5;
  localparam int unsigned ActionW   = 3;

  // Request codes; the two remaining codes fail and change nothing
  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_PEEK_FRONT = 3'd3,
    ACT_PEEK_BACK  = 3'd4,
    ACT_STATUS     = 3'd5
  } action_e;

  // Result of one request, apart from the item word read from the slots
  typedef struct packed {
    logic              success;
    logic              is_empty;
    logic              is_full;
    logic [CountW-1:0] busy_count;
    logic [CountW-1:0] free_count;
    logic [CountW-1:0] free_low_mark;
    logic              read_ok;
  } status_t;

endpackage

### design/rqfp_mem.sv
// ---------------------------------------------------------------------------
// rqfp_mem
// Item slot memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rqfp_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write the slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read the slot; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/rqfp_ctrl.sv
// ---------------------------------------------------------------------------
// rqfp_ctrl
// Queue pointers, full flag, free count and low-water mark. Decodes each
// request, drives the slot memory ports and produces the result status.
// ---------------------------------------------------------------------------
module rqfp_ctrl #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rqfp_pkg::CountW-1:0]         cfg_wdata_i,
  input  logic                                step_i,
  input  logic [rqfp_pkg::ActionW-1:0]        action_i,
  output logic                                we_o,
  output logic [$clog2(MAX_DEPTH)-1:0]        waddr_o,
  output logic                                re_o,
  output logic [$clog2(MAX_DEPTH)-1:0]        raddr_o,
  output rqfp_pkg::status_t                   status_o
);

  import rqfp_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_DEPTH);
  localparam int unsigned CmpW = ((IdxW > CountW) ? IdxW : CountW) + 1;
  localparam logic [CountW-1:0] CapRst =
    (MAX_DEPTH < 16) ? CountW'(MAX_DEPTH) : CountW'(16);

  logic [CountW-1:0] cap_q, free_q, free_d, low_q, low_d;
  logic [IdxW-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic              full_q, full_d;

  logic [CmpW-1:0]   cap_w, rd_w, wr_w, rd_fwd, rd_back, wr_fwd, wr_back;
  logic [CountW-1:0] cfg_cap;
  logic              empty_q, empty_d, push, success;

  // Wrap arithmetic on the pointers against the capacity
  always_comb begin
    cap_w   = CmpW'(cap_q);
    rd_w    = CmpW'(rd_q);
    wr_w    = CmpW'(wr_q);
    rd_fwd  = (rd_w + CmpW'(1) >= cap_w) ? '0 : rd_w + CmpW'(1);
    wr_fwd  = (wr_w + CmpW'(1) >= cap_w) ? '0 : wr_w + CmpW'(1);
    rd_back = (rd_w == '0) ? cap_w - CmpW'(1) : rd_w - CmpW'(1);
    wr_back = (wr_w == '0) ? cap_w - CmpW'(1) : wr_w - CmpW'(1);
  end

  assign empty_q = (rd_q == wr_q) && !full_q;

  // Decode the request and work out the next queue state
  always_comb begin
    rd_d    = rd_q;
    wr_d    = wr_q;
    full_d  = full_q;
    free_d  = free_q;
    low_d   = low_q;
    push    = 1'b0;
    success = 1'b0;
    we_o    = 1'b0;
    waddr_o = wr_q;
    re_o    = 1'b0;
    raddr_o = rd_q;
    unique case (action_e'(action_i))
      ACT_PUSH_BACK: begin
        if (!full_q) begin
          we_o    = step_i;
          waddr_o = wr_q;
          wr_d    = IdxW'(wr_fwd);
          push    = 1'b1;
          success = 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (!full_q) begin
          rd_d    = IdxW'(rd_back);
          we_o    = step_i;
          waddr_o = IdxW'(rd_back);
          push    = 1'b1;
          success = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty_q) begin
          re_o    = step_i;
          raddr_o = rd_q;
          rd_d    = IdxW'(rd_fwd);
          full_d  = 1'b0;
          if (free_q < cap_q) begin
            free_d = free_q + CountW'(1);
          end
          success = 1'b1;
        end
      end
      ACT_PEEK_FRONT: begin
        if (!empty_q) begin
          re_o    = step_i;
          raddr_o = rd_q;
          success = 1'b1;
        end
      end
      ACT_PEEK_BACK: begin
        if (!empty_q) begin
          re_o    = step_i;
          raddr_o = IdxW'(wr_back);
          success = 1'b1;
        end
      end
      ACT_STATUS: begin
        success = 1'b1;
      end
      default: begin
        success = 1'b0;
      end
    endcase
    // Account for a stored item: full when the pointers meet
    if (push) begin
      full_d = (wr_d == rd_d);
      if (free_q != '0) begin
        free_d = free_q - CountW'(1);
      end
      low_d = (free_d < low_q) ? free_d : low_q;
    end
  end

  assign empty_d = (rd_d == wr_d) && !full_d;

  // Build the result status
  always_comb begin
    status_o.success       = success;
    status_o.is_empty      = empty_d;
    status_o.is_full       = full_d;
    status_o.busy_count    = cap_q - free_d;
    status_o.free_count    = free_d;
    status_o.free_low_mark = low_d;
    status_o.read_ok       = success && re_o;
  end

  // Clamp a written capacity to one through the slot count
  always_comb begin
    cfg_cap = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      cfg_cap = CountW'(1);
    end else if (CmpW'(cfg_wdata_i) > CmpW'(MAX_DEPTH)) begin
      cfg_cap = CountW'(MAX_DEPTH);
    end
  end

  // Restart on a capacity write, advance on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapRst;
      rd_q   <= '0;
      wr_q   <= '0;
      full_q <= 1'b0;
      free_q <= CapRst;
      low_q  <= CapRst;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_cap;
      rd_q   <= '0;
      wr_q   <= '0;
      full_q <= 1'b0;
      free_q <= cfg_cap;
      low_q  <= cfg_cap;
    end else if (step_i) begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      full_q <= full_d;
      free_q <= free_d;
      low_q  <= low_d;
    end
  end

  a_full_no_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (free_q == '0))
    else $error("full queue with free slots");

  a_empty_all_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (free_q == cap_q))
    else $error("empty queue with busy slots");

  a_low_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q <= free_q) && (free_q <= cap_q))
    else $error("low-water mark or free count out of order");

  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CmpW'(rd_q) < CmpW'(cap_q)) && (CmpW'(wr_q) < CmpW'(cap_q)))
    else $error("pointer beyond capacity");

endmodule

### design/ring_queue_with_front_push_top.sv
// ---------------------------------------------------------------------------
// ring_queue_with_front_push_top
// Circular item queue with push at back or front, pop, peek and status.
// ---------------------------------------------------------------------------
// One transaction is accepted per clock cycle while the input is not
// stalled. The queue state is updated and the slot memory is read at
// the accepting edge, and the result is formed from the registered read
// data into an output register when the result stage moves on. The slot
// memory has a single read port with registered read data. Input
// is stalled only while both the result stage and the output register hold
// transactions and the output is stalled. Writing the capacity register
// empties the queue at once; write it only while no transaction is in
// flight.
module ring_queue_with_front_push_top #(
  parameter int unsigned MAX_DEPTH  = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rqfp_pkg::CountW-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rqfp_pkg::ActionW-1:0]         action_i,
  input  logic [rqfp_pkg::ItemPortW-1:0]       item_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 success_o,
  output logic [rqfp_pkg::ItemPortW-1:0]       item_out_o,
  output logic                                 is_empty_o,
  output logic                                 is_full_o,
  output logic [rqfp_pkg::CountW-1:0]          busy_count_o,
  output logic [rqfp_pkg::CountW-1:0]          free_count_o,
  output logic [rqfp_pkg::CountW-1:0]          free_low_mark_o
);

  import rqfp_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_DEPTH);

  logic                  accept, s1_move;
  logic                  mem_we, mem_re;
  logic [IdxW-1:0]       mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  status_t               status;

  logic                  s1_valid_q, s1_valid_d;
  status_t               s1_stat_q;
  logic                  out_valid_q, out_valid_d;
  status_t               out_stat_q;
  logic [ItemPortW-1:0]  out_item_q;

  // Handshake: the result stage moves when the output register frees up
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  rqfp_ctrl #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (accept),
    .action_i    (action_i),
    .we_o        (mem_we),
    .waddr_o     (mem_waddr),
    .re_o        (mem_re),
    .raddr_o     (mem_raddr),
    .status_o    (status)
  );

  rqfp_mem #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (ITEM_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (ITEM_WIDTH'(item_in_i)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next valid of the result stage and the output register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the status of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_stat_q <= status;
    end
  end

  // Load the output register, merging in the slot read data
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_stat_q <= s1_stat_q;
      out_item_q <= s1_stat_q.read_ok ? ItemPortW'(mem_rdata) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign success_o       = out_stat_q.success;
  assign item_out_o      = out_item_q;
  assign is_empty_o      = out_stat_q.is_empty;
  assign is_full_o       = out_stat_q.is_full;
  assign busy_count_o    = out_stat_q.busy_count;
  assign free_count_o    = out_stat_q.free_count;
  assign free_low_mark_o = out_stat_q.free_low_mark;

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction lost before the result stage");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  a_move_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("result moved but output register empty");

endmodule
